// ===== hw/rtl/lcsrh_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lcsrh_pkg
// Shared constants, types and modular helpers of the common subpath search.
// ----------------------------------------------------------------------------
package lcsrh_pkg;

   localparam int MAX_SYMBOLS_DEF = 4096;
   localparam int MAX_PATHS_DEF   = 64;
   localparam int SET_ENTRIES_DEF = 4096;
   localparam int CITY_BITS_DEF   = 17;

   localparam int HASH_W    = 30;
   localparam int KEY_SHIFT = 32;
   localparam int KEY_W     = KEY_SHIFT + HASH_W;
   localparam int ENTRY_W   = KEY_W + 1;
   localparam int LEN_W     = 13;
   localparam int RSP_DW    = ((LEN_W + 7) / 8) * 8;

   localparam logic [HASH_W-1:0] BASE_A = 30'd100003;
   localparam logic [HASH_W-1:0] MOD_A  = 30'd1000000007;
   localparam logic [HASH_W-1:0] BASE_B = 30'd100019;
   localparam logic [HASH_W-1:0] MOD_B  = 30'd1000000009;

   localparam logic [31:0] GOLD_HI = 32'h9E3779B9;
   localparam logic [31:0] GOLD_LO = 32'h7F4A7C15;

   typedef struct packed {
      logic              start;
      logic [HASH_W-1:0] a_a;
      logic [HASH_W-1:0] b_a;
      logic [HASH_W-1:0] a_b;
      logic [HASH_W-1:0] b_b;
   } mm_req_type;

   typedef struct packed {
      logic              done;
      logic [HASH_W-1:0] r_a;
      logic [HASH_W-1:0] r_b;
   } mm_rsp_type;

   // (x + y) mod m for x, y below m
   function automatic logic [HASH_W-1:0] mod_add(input logic [HASH_W-1:0] x,
                                                  input logic [HASH_W-1:0] y,
                                                  input logic [HASH_W-1:0] m);
      logic [HASH_W:0] s;
      s = {1'b0, x} + {1'b0, y};
      if (s >= {1'b0, m}) begin
         s = s - {1'b0, m};
      end
      return s[HASH_W-1:0];
   endfunction

endpackage

// ===== hw/rtl/lcsrh_set_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lcsrh_set_ram
// Key set storage: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module lcsrh_set_ram #(
   parameter int DEPTH = lcsrh_pkg::SET_ENTRIES_DEF
) (
   input  logic                            clock,
   input  logic                            wr_en,
   input  logic [$clog2(DEPTH)-1:0]        wr_addr,
   input  logic [lcsrh_pkg::ENTRY_W-1:0]   wr_data,
   input  logic [$clog2(DEPTH)-1:0]        rd_addr,
   output logic [lcsrh_pkg::ENTRY_W-1:0]   rd_data
);

   logic [lcsrh_pkg::ENTRY_W-1:0] mem_ff [DEPTH];
   logic [lcsrh_pkg::ENTRY_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hw/rtl/lcsrh_modmul.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lcsrh_modmul
// Two-lane shift-add modular multiplier, one multiplier bit per cycle.
// ----------------------------------------------------------------------------
module lcsrh_modmul (
   input  logic                    clock,
   input  logic                    reset,
   input  lcsrh_pkg::mm_req_type   req,
   output lcsrh_pkg::mm_rsp_type   rsp
);

   localparam int HW = lcsrh_pkg::HASH_W;
   localparam int CW = $clog2(HW);

   logic          active_ff, active_in;
   logic          done_ff, done_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic [HW-1:0] a_a_ff, a_a_in, b_a_ff, b_a_in, r_a_ff, r_a_in;
   logic [HW-1:0] a_b_ff, a_b_in, b_b_ff, b_b_in, r_b_ff, r_b_in;
   logic [CW-1:0] bit_idx;

   function automatic logic [HW-1:0] mstep(input logic [HW-1:0] r,
                                           input logic [HW-1:0] a,
                                           input logic          bitv,
                                           input logic [HW-1:0] m);
      logic [HW+1:0] t;
      logic [HW+1:0] m1;
      logic [HW+1:0] m2;
      m1 = {2'b00, m};
      m2 = {1'b0, m, 1'b0};
      t  = {1'b0, r, 1'b0} + (bitv ? {2'b00, a} : '0);
      if (t >= m2) begin
         t = t - m2;
      end else if (t >= m1) begin
         t = t - m1;
      end
      return t[HW-1:0];
   endfunction

   assign bit_idx = CW'(HW - 1) - cnt_ff;

   always_comb begin
      active_in = active_ff;
      done_in   = 1'b0;
      cnt_in    = cnt_ff;
      a_a_in    = a_a_ff;
      b_a_in    = b_a_ff;
      r_a_in    = r_a_ff;
      a_b_in    = a_b_ff;
      b_b_in    = b_b_ff;
      r_b_in    = r_b_ff;
      if (req.start) begin
         active_in = 1'b1;
         cnt_in    = '0;
         a_a_in    = req.a_a;
         b_a_in    = req.b_a;
         a_b_in    = req.a_b;
         b_b_in    = req.b_b;
         r_a_in    = '0;
         r_b_in    = '0;
      end else if (active_ff) begin
         r_a_in = mstep(r_a_ff, a_a_ff, b_a_ff[bit_idx], lcsrh_pkg::MOD_A);
         r_b_in = mstep(r_b_ff, a_b_ff, b_b_ff[bit_idx], lcsrh_pkg::MOD_B);
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CW'(HW - 1)) begin
            active_in = 1'b0;
            done_in   = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
         done_ff   <= 1'b0;
      end else begin
         active_ff <= active_in;
         done_ff   <= done_in;
      end
      cnt_ff <= cnt_in;
      a_a_ff <= a_a_in;
      b_a_ff <= b_a_in;
      r_a_ff <= r_a_in;
      a_b_ff <= a_b_in;
      b_b_ff <= b_b_in;
      r_b_ff <= r_b_in;
   end

   assign rsp.done = done_ff;
   assign rsp.r_a  = r_a_ff;
   assign rsp.r_b  = r_b_ff;

endmodule

// ===== hw/rtl/lcsrh_slot.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lcsrh_slot
// Multiplicative hash of a key into a set slot: three partial products,
// then a remainder by the set size through a reciprocal multiply and one
// correction step.
// ----------------------------------------------------------------------------
module lcsrh_slot #(
   parameter int SET_ENTRIES = lcsrh_pkg::SET_ENTRIES_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   input  logic [lcsrh_pkg::KEY_W-1:0]         key,
   output logic                                done,
   output logic [$clog2(SET_ENTRIES)-1:0]      slot
);

   localparam int          SET_AW  = $clog2(SET_ENTRIES);
   localparam int          LAST_ST = 7;
   localparam logic [31:0] DIVISOR = 32'(SET_ENTRIES);
   localparam logic [31:0] RECIP   = 32'((64'd1 << 32) / SET_ENTRIES);

   logic                             active_ff, active_in;
   logic                             done_ff, done_in;
   logic [5:0]                       step_ff, step_in;
   logic [lcsrh_pkg::KEY_W-1:0]      key_ff, key_in;
   logic [63:0]                      prod_ff, prod_in;
   logic [31:0]                      acc_ff, acc_in;
   logic [31:0]                      rem_ff, rem_in;
   logic [31:0]                      op_x, op_y;

   always_comb begin
      case (step_ff)
         6'd0: begin
            op_x = key_ff[31:0];
            op_y = lcsrh_pkg::GOLD_LO;
         end
         6'd1: begin
            op_x = 32'(key_ff[lcsrh_pkg::KEY_W-1:32]);
            op_y = lcsrh_pkg::GOLD_LO;
         end
         6'd4: begin
            op_x = rem_ff;
            op_y = RECIP;
         end
         6'd5: begin
            op_x = prod_ff[63:32];
            op_y = DIVISOR;
         end
         default: begin
            op_x = key_ff[31:0];
            op_y = lcsrh_pkg::GOLD_HI;
         end
      endcase
   end

   always_comb begin
      active_in = active_ff;
      done_in   = 1'b0;
      step_in   = step_ff;
      key_in    = key_ff;
      prod_in   = prod_ff;
      acc_in    = acc_ff;
      rem_in    = rem_ff;
      if (start) begin
         active_in = 1'b1;
         step_in   = '0;
         key_in    = key;
      end else if (active_ff) begin
         step_in = step_ff + 1'b1;
         case (step_ff)
            6'd0: begin
               prod_in = op_x * op_y;
            end
            6'd1: begin
               acc_in  = prod_ff[63:32];
               prod_in = op_x * op_y;
            end
            6'd2: begin
               acc_in  = acc_ff + prod_ff[31:0];
               prod_in = op_x * op_y;
            end
            6'd3: begin
               rem_in = acc_ff + prod_ff[31:0];
            end
            6'd4: begin
               prod_in = op_x * op_y;
            end
            6'd5: begin
               prod_in = op_x * op_y;
            end
            6'd6: begin
               rem_in = rem_ff - prod_ff[31:0];
            end
            default: begin
               if (rem_ff >= DIVISOR) begin
                  rem_in = rem_ff - DIVISOR;
               end
               if (step_ff == 6'(LAST_ST)) begin
                  active_in = 1'b0;
                  done_in   = 1'b1;
               end
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
         done_ff   <= 1'b0;
      end else begin
         active_ff <= active_in;
         done_ff   <= done_in;
      end
      step_ff <= step_in;
      key_ff  <= key_in;
      prod_ff <= prod_in;
      acc_ff  <= acc_in;
      rem_ff  <= rem_in;
   end

   assign done = done_ff;
   assign slot = rem_ff[SET_AW-1:0];

endmodule

// ===== hw/rtl/longest_common_subpath_rolling_hash.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// longest_common_subpath_rolling_hash
// Loads paths of city symbols, then binary-searches the longest window
// length shared by every path with a double rolling hash and key sets.
// ----------------------------------------------------------------------------
// Usage:
//   req channel: one city symbol per item, tlast closes a path, tuser closes
//   the last path and starts the search. Symbols load at one item per cycle
//   into the symbol store.
//   rsp channel: one item per batch with the longest common length and the
//   overflow flag.
//   After the closing item the search runs without accepting items. Each
//   search step builds the power term by repeated modular multiplies, sweeps
//   the next key set (SET_ENTRIES entries) once per path to empty it, and runs
//   one modular multiply per symbol, plus for each window the slot hashing,
//   the set probes and a modular multiply to drop the old symbol. The serial
//   modular multiplier and the slot unit set the search time.
//   A result waiting on a stalled rsp side is held; loading of the next batch
//   goes on meanwhile, and its search ends only once that result is taken.
//   Reset empties the loaded batch; key sets need no reset sweep since each is
//   swept before it is filled.
// ----------------------------------------------------------------------------
module longest_common_subpath_rolling_hash #(
   parameter int MAX_SYMBOLS = lcsrh_pkg::MAX_SYMBOLS_DEF,
   parameter int MAX_PATHS   = lcsrh_pkg::MAX_PATHS_DEF,
   parameter int SET_ENTRIES = lcsrh_pkg::SET_ENTRIES_DEF,
   parameter int CITY_BITS   = lcsrh_pkg::CITY_BITS_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   input  logic [((CITY_BITS + 7) / 8)*8-1:0] req_tdata,   // city
   input  logic                               req_tlast,   // path_end
   input  logic                               req_tuser,   // all_end
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   output logic [lcsrh_pkg::RSP_DW-1:0]       rsp_tdata,   // longest_length
   output logic                               rsp_tuser    // overflow
);

   localparam int SYM_AW  = $clog2(MAX_SYMBOLS);
   localparam int SYM_CW  = $clog2(MAX_SYMBOLS + 1);
   localparam int LW      = SYM_CW + 1;
   localparam int PATH_AW = $clog2(MAX_PATHS);
   localparam int PATH_CW = $clog2(MAX_PATHS + 1);
   localparam int SET_AW  = $clog2(SET_ENTRIES);
   localparam int HW      = lcsrh_pkg::HASH_W;
   localparam int KW      = lcsrh_pkg::KEY_W;
   localparam int EW      = lcsrh_pkg::ENTRY_W;

   typedef enum logic [18:0] {
      S_LOAD = 19'd1,
      S_BS   = 19'd2,
      S_POW  = 19'd4,
      S_PMUL = 19'd8,
      S_PRD  = 19'd16,
      S_PWT  = 19'd32,
      S_CLR  = 19'd64,
      S_SRD  = 19'd128,
      S_SWT  = 19'd256,
      S_HMUL = 19'd512,
      S_SLOT = 19'd1024,
      S_HRD  = 19'd2048,
      S_HCK  = 19'd4096,
      S_ARD  = 19'd8192,
      S_ACK  = 19'd16384,
      S_ORD  = 19'd32768,
      S_OWT  = 19'd65536,
      S_OMUL = 19'd131072,
      S_PFIN = 19'd262144
   } state_type;

   state_type            state_ff, state_in;
   logic [SYM_CW-1:0]    sym_cnt_ff, sym_cnt_in;
   logic [PATH_CW-1:0]   path_cnt_ff, path_cnt_in;
   logic [SYM_CW-1:0]    path_start_ff, path_start_in;
   logic [SYM_CW-1:0]    short_ff, short_in;
   logic                 ovf_ff, ovf_in;
   logic [LW-1:0]        lo_ff, lo_in, hi_ff, hi_in, best_ff, best_in, mid_ff, mid_in;
   logic [SYM_CW-1:0]    pow_cnt_ff, pow_cnt_in;
   logic [HW-1:0]        pa_ff, pa_in, pb_ff, pb_in, ha_ff, ha_in, hb_ff, hb_in;
   logic [HW-1:0]        c_ff, c_in;
   logic [PATH_CW-1:0]   p_ff, p_in;
   logic [SYM_CW-1:0]    start_ff, start_in, end_ff, end_in, i_ff, i_in;
   logic                 sel_ff, sel_in, any_ff, any_in;
   logic [SET_AW-1:0]    idx_ff, idx_in, n_ff, n_in;
   logic [KW-1:0]        key_ff, key_in;
   logic                 rsp_valid_ff, rsp_valid_in, rsp_ovf_ff, rsp_ovf_in;
   logic [lcsrh_pkg::LEN_W-1:0] rsp_len_ff, rsp_len_in;

   logic [CITY_BITS-1:0] sym_mem_ff [MAX_SYMBOLS];
   logic [CITY_BITS-1:0] sym_rdata_ff;
   logic [SYM_CW-1:0]    off_mem_ff [MAX_PATHS];
   logic [SYM_CW-1:0]    off_rdata_ff;
   logic [SYM_AW-1:0]    sym_raddr;
   logic                 sym_we, off_we;

   logic                 req_acc, path_full, sym_full, closing;
   logic [SYM_CW-1:0]    new_cnt, plen, short_new;
   logic [LW:0]          mid_sum;
   logic [LW-1:0]        win_len, old_pos;
   logic [HW-1:0]        ha_add, hb_add;
   logic [KW-1:0]        key_new;
   logic                 last_idx, exhausted;
   logic [SET_AW-1:0]    idx_next;

   lcsrh_pkg::mm_req_type mm_req;
   lcsrh_pkg::mm_rsp_type mm_rsp;
   logic                  slot_start, slot_done;
   logic [SET_AW-1:0]     slot;

   logic                  set_we, we0, we1;
   logic [EW-1:0]         set_wdata, rd0, rd1, shared_rd, next_rd;

   // load side
   assign req_tready = (state_ff == S_LOAD);
   assign req_acc    = req_tvalid && req_tready;
   assign path_full  = (path_cnt_ff == PATH_CW'(MAX_PATHS));
   assign sym_full   = (sym_cnt_ff == SYM_CW'(MAX_SYMBOLS));
   assign new_cnt    = sym_full ? sym_cnt_ff : sym_cnt_ff + 1'b1;
   assign plen       = new_cnt - path_start_ff;
   assign short_new  = ((path_cnt_ff == '0) || (plen < short_ff)) ? plen : short_ff;
   assign closing    = (req_tlast || req_tuser) && !path_full;
   assign sym_we     = req_acc && !path_full && !sym_full;
   assign off_we     = req_acc && closing;

   // search datapath
   assign mid_sum   = {1'b0, lo_ff} + {1'b0, hi_ff};
   assign win_len   = LW'(i_ff) - LW'(start_ff) + 1'b1;
   assign old_pos   = LW'(i_ff) + 1'b1 - mid_ff;
   assign ha_add    = lcsrh_pkg::mod_add(mm_rsp.r_a, c_ff, lcsrh_pkg::MOD_A);
   assign hb_add    = lcsrh_pkg::mod_add(mm_rsp.r_b, c_ff, lcsrh_pkg::MOD_B);
   assign key_new   = (KW'(ha_add) << lcsrh_pkg::KEY_SHIFT) | KW'(hb_add);
   assign last_idx  = (idx_ff == SET_AW'(SET_ENTRIES - 1));
   assign exhausted = (n_ff == SET_AW'(SET_ENTRIES - 1));
   assign idx_next  = last_idx ? '0 : idx_ff + 1'b1;

   assign shared_rd = sel_ff ? rd1 : rd0;
   assign next_rd   = sel_ff ? rd0 : rd1;
   assign we0       = set_we && sel_ff;
   assign we1       = set_we && !sel_ff;

   always_comb begin
      case (state_ff)
         S_ORD:   sym_raddr = old_pos[SYM_AW-1:0];
         default: sym_raddr = i_ff[SYM_AW-1:0];
      endcase
   end

   always_comb begin
      mm_req.start = 1'b0;
      mm_req.a_a   = pa_ff;
      mm_req.b_a   = lcsrh_pkg::BASE_A;
      mm_req.a_b   = pb_ff;
      mm_req.b_b   = lcsrh_pkg::BASE_B;
      case (state_ff)
         S_POW: begin
            mm_req.start = (pow_cnt_ff != '0);
         end
         S_SWT: begin
            mm_req.start = 1'b1;
            mm_req.a_a   = ha_ff;
            mm_req.a_b   = hb_ff;
         end
         S_OWT: begin
            mm_req.start = 1'b1;
            mm_req.a_a   = HW'(sym_rdata_ff);
            mm_req.b_a   = pa_ff;
            mm_req.a_b   = HW'(sym_rdata_ff);
            mm_req.b_b   = pb_ff;
         end
         default: begin
            mm_req.start = 1'b0;
         end
      endcase
   end

   always_comb begin
      state_in      = state_ff;
      sym_cnt_in    = sym_cnt_ff;
      path_cnt_in   = path_cnt_ff;
      path_start_in = path_start_ff;
      short_in      = short_ff;
      ovf_in        = ovf_ff;
      lo_in         = lo_ff;
      hi_in         = hi_ff;
      best_in       = best_ff;
      mid_in        = mid_ff;
      pow_cnt_in    = pow_cnt_ff;
      pa_in         = pa_ff;
      pb_in         = pb_ff;
      ha_in         = ha_ff;
      hb_in         = hb_ff;
      c_in          = c_ff;
      p_in          = p_ff;
      start_in      = start_ff;
      end_in        = end_ff;
      i_in          = i_ff;
      sel_in        = sel_ff;
      any_in        = any_ff;
      idx_in        = idx_ff;
      n_in          = n_ff;
      key_in        = key_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_len_in    = rsp_len_ff;
      rsp_ovf_in    = rsp_ovf_ff;
      slot_start    = 1'b0;
      set_we        = 1'b0;
      set_wdata     = '0;
      case (state_ff)
         S_LOAD: begin
            if (req_acc) begin
               if (path_full) begin
                  ovf_in = 1'b1;
               end else begin
                  if (sym_full) begin
                     ovf_in = 1'b1;
                  end
                  sym_cnt_in = new_cnt;
                  if (closing) begin
                     path_cnt_in   = path_cnt_ff + 1'b1;
                     path_start_in = new_cnt;
                     short_in      = short_new;
                  end
               end
               if (req_tuser) begin
                  lo_in    = '0;
                  best_in  = '0;
                  hi_in    = LW'(closing ? short_new : short_ff);
                  state_in = S_BS;
               end
            end
         end
         S_BS: begin
            if (lo_ff > hi_ff) begin
               if (!rsp_valid_ff || rsp_tready) begin
                  rsp_valid_in  = 1'b1;
                  rsp_len_in    = lcsrh_pkg::LEN_W'(best_ff);
                  rsp_ovf_in    = ovf_ff;
                  sym_cnt_in    = '0;
                  path_cnt_in   = '0;
                  path_start_in = '0;
                  short_in      = '0;
                  ovf_in        = 1'b0;
                  state_in      = S_LOAD;
               end
            end else if (mid_sum[LW:1] == '0) begin
               best_in = '0;
               lo_in   = LW'(1);
            end else begin
               mid_in     = mid_sum[LW:1];
               pow_cnt_in = SYM_CW'(mid_sum[LW:1] - 1'b1);
               pa_in      = HW'(1);
               pb_in      = HW'(1);
               p_in       = '0;
               start_in   = '0;
               state_in   = S_POW;
            end
         end
         S_POW: begin
            state_in = (pow_cnt_ff == '0) ? S_PRD : S_PMUL;
         end
         S_PMUL: begin
            if (mm_rsp.done) begin
               pa_in      = mm_rsp.r_a;
               pb_in      = mm_rsp.r_b;
               pow_cnt_in = pow_cnt_ff - 1'b1;
               state_in   = S_POW;
            end
         end
         S_PRD: begin
            state_in = S_PWT;
         end
         S_PWT: begin
            end_in   = off_rdata_ff;
            idx_in   = '0;
            state_in = S_CLR;
         end
         S_CLR: begin
            set_we = 1'b1;
            idx_in = idx_next;
            if (last_idx) begin
               any_in   = 1'b0;
               ha_in    = '0;
               hb_in    = '0;
               i_in     = start_ff;
               state_in = (start_ff == end_ff) ? S_PFIN : S_SRD;
            end
         end
         S_SRD: begin
            state_in = S_SWT;
         end
         S_SWT: begin
            c_in     = HW'(sym_rdata_ff);
            state_in = S_HMUL;
         end
         S_HMUL: begin
            if (mm_rsp.done) begin
               ha_in = ha_add;
               hb_in = hb_add;
               if (win_len >= mid_ff) begin
                  key_in     = key_new;
                  slot_start = 1'b1;
                  state_in   = S_SLOT;
               end else begin
                  i_in     = i_ff + 1'b1;
                  state_in = (i_ff + 1'b1 == end_ff) ? S_PFIN : S_SRD;
               end
            end
         end
         S_SLOT: begin
            if (slot_done) begin
               idx_in   = slot;
               n_in     = '0;
               state_in = (p_ff == '0) ? S_ARD : S_HRD;
            end
         end
         S_HRD: begin
            state_in = S_HCK;
         end
         S_HCK: begin
            if (!shared_rd[EW-1]) begin
               state_in = S_ORD;
            end else if (shared_rd[KW-1:0] == key_ff) begin
               idx_in   = slot;
               n_in     = '0;
               state_in = S_ARD;
            end else if (exhausted) begin
               state_in = S_ORD;
            end else begin
               idx_in   = idx_next;
               n_in     = n_ff + 1'b1;
               state_in = S_HRD;
            end
         end
         S_ARD: begin
            state_in = S_ACK;
         end
         S_ACK: begin
            if (!next_rd[EW-1]) begin
               set_we    = 1'b1;
               set_wdata = {1'b1, key_ff};
               any_in    = 1'b1;
               state_in  = S_ORD;
            end else if (next_rd[KW-1:0] == key_ff) begin
               state_in = S_ORD;
            end else if (exhausted) begin
               ovf_in   = 1'b1;
               state_in = S_ORD;
            end else begin
               idx_in   = idx_next;
               n_in     = n_ff + 1'b1;
               state_in = S_ARD;
            end
         end
         S_ORD: begin
            state_in = S_OWT;
         end
         S_OWT: begin
            state_in = S_OMUL;
         end
         S_OMUL: begin
            if (mm_rsp.done) begin
               ha_in    = lcsrh_pkg::mod_add(ha_ff, lcsrh_pkg::MOD_A - mm_rsp.r_a,
                                             lcsrh_pkg::MOD_A);
               hb_in    = lcsrh_pkg::mod_add(hb_ff, lcsrh_pkg::MOD_B - mm_rsp.r_b,
                                             lcsrh_pkg::MOD_B);
               i_in     = i_ff + 1'b1;
               state_in = (i_ff + 1'b1 == end_ff) ? S_PFIN : S_SRD;
            end
         end
         S_PFIN: begin
            sel_in = !sel_ff;
            if (!any_ff) begin
               hi_in    = mid_ff - 1'b1;
               state_in = S_BS;
            end else if (p_ff + 1'b1 == path_cnt_ff) begin
               best_in  = mid_ff;
               lo_in    = mid_ff + 1'b1;
               state_in = S_BS;
            end else begin
               p_in     = p_ff + 1'b1;
               start_in = end_ff;
               state_in = S_PRD;
            end
         end
         default: begin
            state_in = S_LOAD;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_LOAD;
         sym_cnt_ff    <= '0;
         path_cnt_ff   <= '0;
         path_start_ff <= '0;
         short_ff      <= '0;
         ovf_ff        <= 1'b0;
         lo_ff         <= '0;
         hi_ff         <= '0;
         best_ff       <= '0;
         sel_ff        <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         sym_cnt_ff    <= sym_cnt_in;
         path_cnt_ff   <= path_cnt_in;
         path_start_ff <= path_start_in;
         short_ff      <= short_in;
         ovf_ff        <= ovf_in;
         lo_ff         <= lo_in;
         hi_ff         <= hi_in;
         best_ff       <= best_in;
         sel_ff        <= sel_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      mid_ff     <= mid_in;
      pow_cnt_ff <= pow_cnt_in;
      pa_ff      <= pa_in;
      pb_ff      <= pb_in;
      ha_ff      <= ha_in;
      hb_ff      <= hb_in;
      c_ff       <= c_in;
      p_ff       <= p_in;
      start_ff   <= start_in;
      end_ff     <= end_in;
      i_ff       <= i_in;
      any_ff     <= any_in;
      idx_ff     <= idx_in;
      n_ff       <= n_in;
      key_ff     <= key_in;
      rsp_len_ff <= rsp_len_in;
      rsp_ovf_ff <= rsp_ovf_in;
   end

   always_ff @(posedge clock) begin
      if (sym_we) begin
         sym_mem_ff[sym_cnt_ff[SYM_AW-1:0]] <= req_tdata[CITY_BITS-1:0];
      end
      sym_rdata_ff <= sym_mem_ff[sym_raddr];
   end

   always_ff @(posedge clock) begin
      if (off_we) begin
         off_mem_ff[path_cnt_ff[PATH_AW-1:0]] <= new_cnt;
      end
      off_rdata_ff <= off_mem_ff[p_ff[PATH_AW-1:0]];
   end

   lcsrh_modmul u_modmul (
      .clock (clock),
      .reset (reset),
      .req   (mm_req),
      .rsp   (mm_rsp)
   );

   lcsrh_slot #(
      .SET_ENTRIES (SET_ENTRIES)
   ) u_slot (
      .clock (clock),
      .reset (reset),
      .start (slot_start),
      .key   (key_new),
      .done  (slot_done),
      .slot  (slot)
   );

   lcsrh_set_ram #(
      .DEPTH (SET_ENTRIES)
   ) u_set0 (
      .clock   (clock),
      .wr_en   (we0),
      .wr_addr (idx_ff),
      .wr_data (set_wdata),
      .rd_addr (idx_ff),
      .rd_data (rd0)
   );

   lcsrh_set_ram #(
      .DEPTH (SET_ENTRIES)
   ) u_set1 (
      .clock   (clock),
      .wr_en   (we1),
      .wr_addr (idx_ff),
      .wr_data (set_wdata),
      .rd_addr (idx_ff),
      .rd_data (rd1)
   );

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = lcsrh_pkg::RSP_DW'(rsp_len_ff);
   assign rsp_tuser  = rsp_ovf_ff;

   a_bounds: assert property (@(posedge clock) disable iff (reset)
      (state_ff != S_LOAD) |-> ({1'b0, lo_ff} <= {1'b0, hi_ff} + 1'b1))
      else $error("search bounds crossed by more than one");

   a_sym_in_path: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SRD) |-> (i_ff < end_ff))
      else $error("symbol read past end of path");

   a_slot_done: assert property (@(posedge clock) disable iff (reset)
      slot_done |-> (state_ff == S_SLOT))
      else $error("slot result outside slot wait");

   a_mm_done: assert property (@(posedge clock) disable iff (reset)
      mm_rsp.done |-> (state_ff == S_PMUL || state_ff == S_HMUL || state_ff == S_OMUL))
      else $error("multiplier result outside multiply wait");

endmodule

// ===== tb/sv/longest_common_subpath_rolling_hash_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// longest_common_subpath_rolling_hash_test
// Streams batches of paths into the block and checks every result (longest
// common window length and overflow flag) against a local double rolling
// hash predictor. Covers field extremes, single paths, a full path count,
// random gaps on both sides and a long receiver hold-off.
// ----------------------------------------------------------------------------
module longest_common_subpath_rolling_hash_test;

   localparam int          CITY_W     = lcsrh_pkg::CITY_BITS_DEF;
   localparam int          LEN_W      = lcsrh_pkg::LEN_W;
   localparam int          REQ_DW     = ((CITY_W + 7) / 8) * 8;
   localparam int          RSP_DW     = lcsrh_pkg::RSP_DW;
   localparam longint      CYCLE_CAP  = 40000000;
   localparam longint unsigned HB_A   = 100003;
   localparam longint unsigned HM_A   = 1000000007;
   localparam longint unsigned HB_B   = 100019;
   localparam longint unsigned HM_B   = 1000000009;

   typedef struct {
      logic [CITY_W-1:0] city;
      logic              path_end;
      logic              all_end;
   } hop_type;

   typedef struct {
      logic [LEN_W-1:0] longest;
      logic             overflow;
   } answer_type;

   logic              clock;
   logic              reset;
   logic              req_tvalid;
   logic              req_tready;
   logic [REQ_DW-1:0] req_tdata;
   logic              req_tlast;
   logic              req_tuser;
   logic              rsp_tvalid;
   logic              rsp_tready;
   logic [RSP_DW-1:0] rsp_tdata;
   logic              rsp_tuser;

   hop_type     hop_q[$];
   answer_type  answer_q[$];
   int unsigned city_store[$];
   int unsigned path_ends[$];
   bit          ovf_seen;
   int          send_idle_pct;
   int          recv_idle_pct;
   int          hold_cycles;
   int          errors;
   longint      cycles;
   int          hop_count;

   longest_common_subpath_rolling_hash dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),   // city
      .req_tlast  (req_tlast),   // path_end
      .req_tuser  (req_tuser),   // all_end
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),   // longest_length
      .rsp_tuser  (rsp_tuser)    // overflow
   );

   always begin
      clock = 1'b1;
      #6;
      clock = 1'b0;
      #6;
   end

   function automatic bit window_shared(int unsigned len);
      longint unsigned pa, pb, ha, hb, key, old;
      bit              shared[longint unsigned];
      bit              nxt[longint unsigned];
      int unsigned     start;
      pa = 1;
      pb = 1;
      start = 0;
      if (len == 0) return 1'b1;
      for (int unsigned i = 0; i + 1 < len; i++) begin
         pa = (pa * HB_A) % HM_A;
         pb = (pb * HB_B) % HM_B;
      end
      for (int p = 0; p < path_ends.size(); p++) begin
         nxt.delete();
         ha = 0;
         hb = 0;
         for (int unsigned i = start; i < path_ends[p]; i++) begin
            ha = (ha * HB_A + city_store[i]) % HM_A;
            hb = (hb * HB_B + city_store[i]) % HM_B;
            if (i - start + 1 >= len) begin
               key = (ha << 32) | hb;
               old = city_store[i + 1 - len];
               if (p == 0 || shared.exists(key)) nxt[key] = 1'b1;
               ha = (ha + HM_A - (old * pa) % HM_A) % HM_A;
               hb = (hb + HM_B - (old * pb) % HM_B) % HM_B;
            end
         end
         shared = nxt;
         if (shared.size() == 0) return 1'b0;
         start = path_ends[p];
      end
      return 1'b1;
   endfunction

   function automatic int unsigned longest_shared();
      int unsigned start, shortest, l;
      int          lo, hi, mid, best;
      start = 0;
      shortest = 0;
      best = 0;
      if (path_ends.size() == 0) return 0;
      for (int p = 0; p < path_ends.size(); p++) begin
         l = path_ends[p] - start;
         if (p == 0 || l < shortest) shortest = l;
         start = path_ends[p];
      end
      lo = 0;
      hi = shortest;
      while (lo <= hi) begin
         mid = lo + (hi - lo) / 2;
         if (window_shared(mid)) begin
            best = mid;
            lo = mid + 1;
         end else begin
            hi = mid - 1;
         end
      end
      return best;
   endfunction

   task automatic absorb_hop(hop_type h);
      answer_type a;
      if (path_ends.size() >= lcsrh_pkg::MAX_PATHS_DEF) begin
         ovf_seen = 1'b1;
      end else begin
         if (city_store.size() < lcsrh_pkg::MAX_SYMBOLS_DEF) city_store.push_back(32'(h.city));
         else ovf_seen = 1'b1;
         if (h.path_end || h.all_end) path_ends.push_back(32'(city_store.size()));
      end
      if (h.all_end) begin
         a.longest = LEN_W'(longest_shared());
         a.overflow = ovf_seen;
         answer_q.push_back(a);
         city_store.delete();
         path_ends.delete();
         ovf_seen = 1'b0;
      end
   endtask

   task automatic push_hop(int unsigned city, bit pend, bit aend);
      hop_type h;
      h.city = CITY_W'(city);
      h.path_end = pend;
      h.all_end = aend;
      hop_q.push_back(h);
      hop_count++;
   endtask

   // random batch: paths share a motif so that long windows often match
   task automatic push_batch();
      int unsigned motif[$];
      int          npaths, pre, post, alpha;
      bit          wide;
      npaths = $urandom_range(1, 4);
      wide = ($urandom_range(7) == 0);
      alpha = $urandom_range(1, 5);
      repeat ($urandom_range(0, 5)) motif.push_back($urandom_range(alpha));
      for (int p = 0; p < npaths; p++) begin
         pre = $urandom_range(0, 3);
         post = $urandom_range(0, 3);
         if (motif.size() + pre + post == 0) post = 1;
         for (int i = 0; i < pre + motif.size() + post; i++) begin
            int unsigned c;
            if (i >= pre && i < pre + motif.size()) c = motif[i - pre];
            else if (wide) c = $urandom_range((1 << CITY_W) - 1);
            else c = $urandom_range(alpha);
            push_hop(c, (i == pre + motif.size() + post - 1),
                     (p == npaths - 1) && (i == pre + motif.size() + post - 1));
         end
      end
   endtask

   task automatic drain();
      while (hop_q.size() != 0 || req_tvalid || answer_q.size() != 0) @(posedge clock);
   endtask

   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         req_tdata <= '0;
         req_tlast <= 1'b0;
         req_tuser <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            hop_type h;
            h.city = req_tdata[CITY_W-1:0];
            h.path_end = req_tlast;
            h.all_end = req_tuser;
            absorb_hop(h);
         end
         if (!req_tvalid || req_tready) begin
            if (hop_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
               hop_type h;
               h = hop_q.pop_front();
               req_tvalid <= 1'b1;
               req_tdata <= REQ_DW'(h.city);
               req_tlast <= h.path_end;
               req_tuser <= h.all_end;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (answer_q.size() == 0) begin
               $display("%0t: unexpected result len=%0d ovf=%0d", $time,
                        rsp_tdata[LEN_W-1:0], rsp_tuser);
               errors++;
            end else begin
               answer_type a;
               a = answer_q.pop_front();
               if (rsp_tdata[LEN_W-1:0] !== a.longest) begin
                  $display("%0t: longest_length expected %0d actual %0d", $time,
                           a.longest, rsp_tdata[LEN_W-1:0]);
                  errors++;
               end
               if (rsp_tuser !== a.overflow) begin
                  $display("%0t: overflow expected %0d actual %0d", $time,
                           a.overflow, rsp_tuser);
                  errors++;
               end
            end
         end
         if (hold_cycles > 0) begin
            hold_cycles <= hold_cycles - 1;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
         end
      end
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_CAP) begin
         $display("longest_common_subpath_rolling_hash_test NOT OK");
         $finish;
      end
   end

   initial begin
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      req_tlast = 1'b0;
      req_tuser = 1'b0;
      rsp_tready = 1'b0;
      send_idle_pct = 0;
      recv_idle_pct = 0;
      hold_cycles = 0;
      errors = 0;
      cycles = 0;
      hop_count = 0;
      ovf_seen = 1'b0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // extremes, single path, two matching paths
      push_hop((1 << CITY_W) - 1, 1'b0, 1'b1);
      push_hop(0, 1'b0, 1'b0);
      push_hop((1 << CITY_W) - 1, 1'b0, 1'b0);
      push_hop(0, 1'b0, 1'b1);
      push_hop(7, 1'b0, 1'b0);
      push_hop(9, 1'b1, 1'b0);
      push_hop(3, 1'b0, 1'b0);
      push_hop(7, 1'b0, 1'b0);
      push_hop(9, 1'b0, 1'b1);
      push_hop(1, 1'b1, 1'b0);
      push_hop(2, 1'b0, 1'b1);
      drain();

      // path count full: later paths dropped, closing item still searches
      for (int p = 0; p < lcsrh_pkg::MAX_PATHS_DEF + 3; p++)
         push_hop((p == 1) ? (1 << CITY_W) - 1 : p, 1'b1,
                  p == lcsrh_pkg::MAX_PATHS_DEF + 2);
      drain();

      send_idle_pct = 38;
      recv_idle_pct = 82;
      while (hop_count < 470) push_batch();
      drain();

      // long receiver hold-off while the sender keeps offering
      send_idle_pct = 82;
      recv_idle_pct = 38;
      push_batch();
      push_batch();
      push_batch();
      hold_cycles <= 200000;
      while (hop_count < 940) push_batch();
      drain();

      send_idle_pct = 0;
      recv_idle_pct = 0;
      while (hop_count < 1400) push_batch();
      drain();

      repeat (200) @(posedge clock);
      if (errors == 0) begin
         $display("longest_common_subpath_rolling_hash_test OK");
      end else begin
         $display("longest_common_subpath_rolling_hash_test NOT OK");
      end
      $finish;
   end

endmodule
